[design/depth_tree_navigator_top_defines.svh]
// Assertion macros of the depth tree navigator, used by its controller.
`ifndef DEPTH_TREE_NAVIGATOR_TOP_DEFINES_SVH
`define DEPTH_TREE_NAVIGATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define DTN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DTN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTN_ASSERT(lbl, prop, msg)
`define DTN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/dtn_pkg.sv]
// Shared types, codes and defaults of the depth tree navigator.
package dtn_pkg;
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int DEPTH_BITS_DEF    = 4;
	localparam int REQ_W             = 3;
	localparam int INDEX_W           = 8;
	localparam int LOAD_DEPTH_W      = 4;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD   = 3'd0,
		REQ_PARENT = 3'd1,
		REQ_CHILD  = 3'd2,
		REQ_NEXT   = 3'd3,
		REQ_PREV   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SELF,
		ST_WALK,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic load_wr;
		logic start;
		logic save_self;
		logic step_up;
		logic step_dn;
		logic set_res;
		logic res_found;
		logic out_load;
	} dtn_cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic [REQ_W-1:0] req;
		logic             stop;
		logic             pos_first;
		logic             pos_last;
		logic             self_d_zero;
		logic             self_d_max;
		logic             self_sub;
		logic             parent_hit;
		logic             sib_hit;
		logic             sib_shallow;
		logic             child_hit;
		logic             out_free;
	} dtn_sts_t;
endpackage

[design/dtn_channels.sv]
// Valid/ready channel interfaces for queries and answers.
interface dtn_query_if;
	import dtn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [INDEX_W-1:0]      entry_index;
	logic [LOAD_DEPTH_W-1:0] load_depth;
	logic                    load_is_submenu;
	logic                    load_is_boundary;

	modport source (output valid, req_type, entry_index, load_depth, load_is_submenu,
		load_is_boundary, input ready);
	modport sink (input valid, req_type, entry_index, load_depth, load_is_submenu,
		load_is_boundary, output ready);
endinterface

interface dtn_answer_if;
	import dtn_pkg::*;
	logic               valid;
	logic               ready;
	logic               found;
	logic [INDEX_W-1:0] target_index;

	modport source (output valid, found, target_index, input ready);
	modport sink (input valid, found, target_index, output ready);
endinterface

[design/dtn_datapath.sv]
// Table memory, walk position, result and answer registers of the navigator.
module dtn_datapath import dtn_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dtn_cmd_t                cmd,
	output dtn_sts_t                sts,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [INDEX_W-1:0]      entry_index,
	input  logic [LOAD_DEPTH_W-1:0] load_depth,
	input  logic                    load_is_submenu,
	input  logic                    load_is_boundary,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [INDEX_W-1:0]      target_index
);
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_ENTRIES - 1);

	logic [DEPTH_BITS-1:0] depth_mem [TABLE_ENTRIES];
	logic                  sub_mem   [TABLE_ENTRIES];
	logic                  bnd_mem   [TABLE_ENTRIES];

	logic [IDX_W-1:0]              clr_q;
	logic [IDX_W-1:0]              pos_q;
	logic [IDX_W-1:0]              rd_addr;
	logic [IDX_W-1:0]              wr_addr;
	logic [REQ_W-1:0]              req_q;
	logic                          oor_q;
	logic [DEPTH_BITS-1:0]         d_q;
	logic [DEPTH_BITS-1:0]         rd_depth_q;
	logic                          rd_sub_q;
	logic                          rd_bnd_q;
	logic                          out_valid_q;
	logic                          out_found_q;
	logic [INDEX_W-1:0]            out_idx_q;
	logic                          res_found_q;
	logic [INDEX_W-1:0]            res_idx_q;
	logic [IDX_W+INDEX_W-1:0]      idx_wide;
	logic [IDX_W+INDEX_W-1:0]      pos_wide;
	logic [LOAD_DEPTH_W+DEPTH_BITS-1:0] ld_wide;
	logic [IDX_W-1:0]              idx_pos;
	logic [INDEX_W-1:0]            pos_idx;
	logic                          idx_in_range;
	logic                          mem_wr;

	assign idx_wide     = {{IDX_W{1'b0}}, entry_index};
	assign idx_pos      = idx_wide[IDX_W-1:0];
	assign pos_wide     = {{INDEX_W{1'b0}}, pos_q};
	assign pos_idx      = pos_wide[INDEX_W-1:0];
	assign ld_wide      = {{DEPTH_BITS{1'b0}}, load_depth};
	assign idx_in_range = int'(entry_index) < TABLE_ENTRIES;
	assign mem_wr       = cmd.clr_wr || (cmd.load_wr && idx_in_range);
	assign wr_addr      = cmd.clr_wr ? clr_q : idx_pos;

	always_comb begin
		priority if (cmd.start) begin
			rd_addr = idx_pos;
		end else if (cmd.step_up) begin
			rd_addr = pos_q + IDX_W'(1);
		end else if (cmd.step_dn) begin
			rd_addr = pos_q - IDX_W'(1);
		end else begin
			rd_addr = pos_q;
		end
	end

	// The boundary store is swept to all ones after reset; the others are not.
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			bnd_mem[wr_addr] <= cmd.clr_wr ? 1'b1 : load_is_boundary;
		end
		if (cmd.load_wr && idx_in_range) begin
			depth_mem[wr_addr] <= ld_wide[DEPTH_BITS-1:0];
			sub_mem[wr_addr]   <= load_is_submenu;
		end
		rd_depth_q <= depth_mem[rd_addr];
		rd_sub_q   <= sub_mem[rd_addr];
		rd_bnd_q   <= bnd_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= rd_addr;
		if (cmd.start) begin
			req_q <= req_type;
			oor_q <= !idx_in_range;
		end
		if (cmd.save_self) begin
			d_q <= rd_depth_q;
		end
		if (cmd.set_res) begin
			res_found_q <= cmd.res_found;
			res_idx_q   <= cmd.res_found ? pos_idx : '0;
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
		end
	end

	always_comb begin
		sts.clr_last    = clr_q == LAST_POS;
		sts.req         = req_q;
		sts.stop        = oor_q || rd_bnd_q;
		sts.pos_first   = pos_q == '0;
		sts.pos_last    = pos_q == LAST_POS;
		sts.self_d_zero = rd_depth_q == '0;
		sts.self_d_max  = &rd_depth_q;
		sts.self_sub    = rd_sub_q;
		sts.parent_hit  = (d_q != '0) && (rd_depth_q == d_q - DEPTH_BITS'(1));
		sts.sib_hit     = rd_depth_q == d_q;
		sts.sib_shallow = rd_depth_q < d_q;
		sts.child_hit   = rd_depth_q == d_q + DEPTH_BITS'(1);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign target_index = out_idx_q;
endmodule

[design/dtn_controller.sv]
// Sequencer of the navigator: clearing pass, request decode and table walk.
module dtn_controller import dtn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  dtn_sts_t         sts,
	output dtn_cmd_t         cmd
);
	`include "depth_tree_navigator_top_defines.svh"

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (req_type == REQ_LOAD) begin
						cmd.load_wr = 1'b1;
					end else if (req_type == REQ_PARENT || req_type == REQ_CHILD ||
						req_type == REQ_NEXT || req_type == REQ_PREV) begin
						cmd.start = 1'b1;
						state_d   = ST_SELF;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SELF: begin
				if (sts.stop) begin
					cmd.set_res = 1'b1;
					state_d     = ST_PUSH;
				end else begin
					cmd.save_self = 1'b1;
					state_d       = ST_WALK;
					unique case (sts.req)
						REQ_PARENT: begin
							if (sts.self_d_zero || sts.pos_first) begin
								cmd.set_res = 1'b1;
								state_d     = ST_PUSH;
							end else begin
								cmd.step_dn = 1'b1;
							end
						end
						REQ_CHILD: begin
							if (!sts.self_sub || sts.self_d_max || sts.pos_last) begin
								cmd.set_res = 1'b1;
								state_d     = ST_PUSH;
							end else begin
								cmd.step_up = 1'b1;
							end
						end
						REQ_NEXT: begin
							if (sts.pos_last) begin
								cmd.set_res = 1'b1;
								state_d     = ST_PUSH;
							end else begin
								cmd.step_up = 1'b1;
							end
						end
						REQ_PREV: begin
							if (sts.pos_first) begin
								cmd.set_res = 1'b1;
								state_d     = ST_PUSH;
							end else begin
								cmd.step_dn = 1'b1;
							end
						end
						default: begin
							cmd.set_res = 1'b1;
							state_d     = ST_PUSH;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (sts.stop) begin
					cmd.set_res = 1'b1;
					state_d     = ST_PUSH;
				end else begin
					unique case (sts.req)
						REQ_PARENT: begin
							if (sts.parent_hit || sts.pos_first) begin
								cmd.set_res   = 1'b1;
								cmd.res_found = sts.parent_hit;
								state_d       = ST_PUSH;
							end else begin
								cmd.step_dn = 1'b1;
							end
						end
						REQ_CHILD: begin
							cmd.set_res   = 1'b1;
							cmd.res_found = sts.child_hit;
							state_d       = ST_PUSH;
						end
						REQ_NEXT: begin
							if (sts.sib_hit || sts.sib_shallow || sts.pos_last) begin
								cmd.set_res   = 1'b1;
								cmd.res_found = sts.sib_hit;
								state_d       = ST_PUSH;
							end else begin
								cmd.step_up = 1'b1;
							end
						end
						REQ_PREV: begin
							if (sts.sib_hit || sts.sib_shallow || sts.pos_first) begin
								cmd.set_res   = 1'b1;
								cmd.res_found = sts.sib_hit;
								state_d       = ST_PUSH;
							end else begin
								cmd.step_dn = 1'b1;
							end
						end
						default: begin
							cmd.set_res = 1'b1;
							state_d     = ST_PUSH;
						end
					endcase
				end
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The answer register is only overwritten once its old answer has left.
	`DTN_ASSERT(a_out_load_free, cmd.out_load |-> sts.out_free, "answer overwritten")
	// A walk never steps past either end of the table.
	`DTN_ASSERT(a_step_up_end, cmd.step_up |-> !sts.pos_last, "walk past table end")
	`DTN_ASSERT(a_step_dn_end, cmd.step_dn |-> !sts.pos_first, "walk before table start")
	// A started query always leaves the idle state and never takes a second one.
	`DTN_ASSERT(a_start_leaves_idle, cmd.start |=> !in_ready, "query started twice")
endmodule

[design/depth_tree_navigator_top.sv]
// Top level of the depth tree navigator: preorder tree table with relative queries.
// The block keeps a tree as a preorder table of TABLE_ENTRIES entries, each with a
// depth, a submenu mark and a boundary mark. A load transfer (req_type 0) writes one
// entry and gives no answer; loads at positions beyond the table and request
// codes 5 to 7 are dropped. Parent, first child, next sibling and previous sibling
// queries each give exactly one answer transfer carrying found and the target
// position (0 when nothing is found). The table sits in a single-port read memory
// with registered read data, and the walk reads one entry per cycle. A walk covers
// at most TABLE_ENTRIES - 1 entries, one for first child, none when the queried
// entry itself is a boundary or out of range. The query channel takes one item at
// a time and is ready again in the cycle after the answer is registered, even if
// that answer still waits on the answer channel. After reset a clearing pass marks
// every entry as a boundary, one entry per cycle, so the query channel is not
// ready until the pass is done. Entries that were never loaded read as boundaries,
// which ends every walk there.
module depth_tree_navigator_top import dtn_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dtn_query_if.sink    query,
	dtn_answer_if.source answer
);
	dtn_cmd_t cmd;
	dtn_sts_t sts;

	// Sequencing lives in the controller; the table and all payload in the datapath.
	dtn_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (query.valid),
		.in_ready (query.ready),
		.req_type (query.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtn_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.DEPTH_BITS    (DEPTH_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_type         (query.req_type),
		.entry_index      (query.entry_index),
		.load_depth       (query.load_depth),
		.load_is_submenu  (query.load_is_submenu),
		.load_is_boundary (query.load_is_boundary),
		.out_valid        (answer.valid),
		.out_ready        (answer.ready),
		.found            (answer.found),
		.target_index     (answer.target_index)
	);
endmodule

[bench/tb_top.sv]
// Self-checking bench for the depth tree navigator: table loads and relative queries.
`timescale 1ns / 100ps

module tb_top;
	import dtn_pkg::*;

	localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int DEPTH_BITS    = DEPTH_BITS_DEF;
	localparam int MAX_DEPTH     = (1 << DEPTH_BITS) - 1;
	localparam int ITEM_TARGET   = 650;
	// Cycles without any transfer before the run is declared hung. The slowest
	// legal gap is the clearing pass or one full-table walk.
	localparam int STALL_LIMIT   = 20000;
	// Request codes above the last defined one are dropped by the block.
	localparam logic [REQ_W-1:0] REQ_UNDEF_FIRST = 3'd5;

	// One query channel item as the bench sees it.
	typedef struct packed {
		logic [REQ_W-1:0]        req;
		logic [INDEX_W-1:0]      idx;
		logic [LOAD_DEPTH_W-1:0] depth;
		logic                    sub;
		logic                    bnd;
	} nav_item_t;

	// One expected answer.
	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] target;
	} nav_answer_t;

	// Pacing of the two channels; it moves on every 60 accepted items.
	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dtn_query_if  query ();
	dtn_answer_if answer ();

	// Bench-side copies of what is driven into the block, known from time zero.
	logic      q_valid   = 1'b0;
	nav_item_t q_item    = '0;
	logic      ans_ready = 1'b0;
	logic      q_taken   = 1'b0;

	assign query.valid            = q_valid;
	assign query.req_type         = q_item.req;
	assign query.entry_index      = q_item.idx;
	assign query.load_depth       = q_item.depth;
	assign query.load_is_submenu  = q_item.sub;
	assign query.load_is_boundary = q_item.bnd;
	assign answer.ready           = ans_ready;

	depth_tree_navigator_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.DEPTH_BITS   (DEPTH_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query),
		.answer(answer)
	);

	always #2 clk = ~clk;

	// Items waiting to be driven, and answers the block still owes.
	nav_item_t   pend_q[$];
	nav_answer_t answer_due_q[$];

	// The bench's own copy of the tree table. Depth and submenu marks of
	// entries that were never loaded are held at zero; they are never read,
	// since such entries are boundaries and every walk stops there.
	logic [DEPTH_BITS-1:0] depth_mem [TABLE_ENTRIES];
	logic                  sub_mem   [TABLE_ENTRIES];
	logic                  bnd_mem   [TABLE_ENTRIES];

	int item_cnt     = 0;
	int accepted_cnt = 0;
	int load_cnt     = 0;
	int checked_cnt  = 0;
	int hit_cnt      = 0;
	int fail_cnt     = 0;
	int stall_cycles = 0;

	function automatic bit coin(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Positions off either end of the table act as boundaries.
	function automatic bit is_wall(input int pos);
		if (pos < 0 || pos >= TABLE_ENTRIES)
			return 1'b1;
		return bnd_mem[pos];
	endfunction

	// Walks away from start one entry at a time. A parent search looks for the
	// first entry exactly one level shallower; a sibling search takes the first
	// entry of equal depth and gives up on a shallower one.
	function automatic bit walk_relative(input int start, input int dir, input bit sibling,
		output int hit);
		int pos;
		int own;
		int seen;
		pos = start;
		own = depth_mem[start];
		hit = 0;
		while (1) begin
			pos = pos + dir;
			if (is_wall(pos))
				return 1'b0;
			seen = depth_mem[pos];
			if (!sibling) begin
				if (own != 0 && seen == own - 1) begin
					hit = pos;
					return 1'b1;
				end
			end else begin
				if (seen < own)
					return 1'b0;
				if (seen == own) begin
					hit = pos;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Applies one accepted item to the table copy. Returns 1 when the item
	// owes an answer, with that answer in ans.
	function automatic bit navigate(input nav_item_t it, output nav_answer_t ans);
		int  pos;
		int  hit;
		int  own;
		bit  hit_ok;
		pos    = it.idx;
		hit    = 0;
		hit_ok = 1'b0;
		ans    = '0;
		if (it.req == REQ_LOAD) begin
			if (pos < TABLE_ENTRIES) begin
				depth_mem[pos] = DEPTH_BITS'(it.depth);
				sub_mem[pos]   = it.sub;
				bnd_mem[pos]   = it.bnd;
			end
			return 1'b0;
		end
		if (it.req >= REQ_UNDEF_FIRST)
			return 1'b0;
		if (!is_wall(pos)) begin
			case (it.req)
				REQ_PARENT: hit_ok = walk_relative(pos, -1, 1'b0, hit);
				REQ_CHILD: begin
					own = depth_mem[pos];
					if (sub_mem[pos] && own < MAX_DEPTH && !is_wall(pos + 1) &&
						depth_mem[pos + 1] == own + 1) begin
						hit_ok = 1'b1;
						hit    = pos + 1;
					end
				end
				REQ_NEXT: hit_ok = walk_relative(pos, 1, 1'b1, hit);
				default:  hit_ok = walk_relative(pos, -1, 1'b1, hit);
			endcase
		end
		ans.found  = hit_ok;
		ans.target = hit_ok ? INDEX_W'(hit) : '0;
		return 1'b1;
	endfunction

	task automatic push_item(input logic [REQ_W-1:0] req, input int idx, input int depth,
		input bit sub, input bit bnd);
		nav_item_t it;
		it.req   = req;
		it.idx   = INDEX_W'(idx);
		it.depth = LOAD_DEPTH_W'(depth);
		it.sub   = sub;
		it.bnd   = bnd;
		pend_q.push_back(it);
		// Dropped request codes do not count toward the stimulus size.
		if (req < REQ_UNDEF_FIRST)
			item_cnt++;
	endtask

	// A query with random, ignored load fields.
	task automatic push_query(input int idx);
		push_item(REQ_W'(REQ_PARENT + $urandom_range(0, 3)), idx, $urandom_range(0, 15),
			$urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	// Loads a well-formed preorder subtree of len entries at base, usually fenced
	// by boundaries, then queries in and around it. A few entries get a random
	// depth so that broken trees are seen too.
	task automatic add_tree(input int base, input int len);
		int dep [TABLE_ENTRIES];
		int deep_pct;
		int nq;
		int r;
		int idx;
		deep_pct = $urandom_range(15, 50);
		dep[0] = coin(25) ? $urandom_range(0, MAX_DEPTH) : $urandom_range(0, 1);
		for (int i = 1; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (coin(4))
				dep[i] = $urandom_range(0, MAX_DEPTH);
			else if (r < deep_pct && dep[i-1] < MAX_DEPTH)
				dep[i] = dep[i-1] + 1;
			else if (r < deep_pct + 40)
				dep[i] = dep[i-1];
			else
				dep[i] = $urandom_range(0, dep[i-1]);
		end
		if (base > 0 && coin(70))
			push_item(REQ_LOAD, base - 1, $urandom_range(0, 15), $urandom_range(0, 1), 1'b1);
		for (int i = 0; i < len; i++)
			push_item(REQ_LOAD, base + i, dep[i],
				(i < len - 1 && dep[i+1] > dep[i]) ? 1'b1 : coin(25), coin(2));
		if (base + len < TABLE_ENTRIES && coin(70))
			push_item(REQ_LOAD, base + len, $urandom_range(0, 15), $urandom_range(0, 1), 1'b1);
		nq = $urandom_range(4, 4 + ((len < 20) ? len : 20));
		for (int k = 0; k < nq; k++) begin
			idx = base - 1 + $urandom_range(0, len + 1);
			if (idx < 0)
				idx = 0;
			if (idx > TABLE_ENTRIES - 1)
				idx = TABLE_ENTRIES - 1;
			push_query(idx);
		end
	endtask

	// Monitor: clears the table copy while reset is low, then at each rising
	// edge scores an answer transfer against the oldest expectation and runs
	// the predictor on a query transfer. The answer is scored first, so an
	// answer and the next query in the same cycle are kept in order.
	always @(posedge clk) begin : monitor
		nav_answer_t want;
		nav_answer_t due;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				depth_mem[i] = '0;
				sub_mem[i]   = 1'b0;
				bnd_mem[i]   = 1'b1;
			end
			q_taken <= 1'b0;
		end else begin
			if (answer.valid && answer.ready) begin
				if (answer_due_q.size() == 0) begin
					$error("answer transfer with no query outstanding: found=%0d target_index=%0d",
						answer.found, answer.target_index);
					fail_cnt++;
				end else begin
					want = answer_due_q.pop_front();
					checked_cnt++;
					if (answer.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, answer.found);
						fail_cnt++;
					end
					if (answer.target_index !== want.target) begin
						$error("target_index: expected %0d, got %0d", want.target,
							answer.target_index);
						fail_cnt++;
					end
				end
			end
			if (query.valid && query.ready) begin
				accepted_cnt++;
				if (q_item.req == REQ_LOAD)
					load_cnt++;
				if (navigate(q_item, due)) begin
					answer_due_q.push_back(due);
					if (due.found)
						hit_cnt++;
				end
			end
			q_taken <= query.valid && query.ready;
			if ((query.valid && query.ready) || (answer.valid && answer.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Driver: at the falling edge, once the current item has been transferred
	// (or nothing is on the channel), either present the next pending item or
	// leave the channel idle. Valid never drops while an item waits. The answer
	// ready line is redrawn every cycle according to the pacing phase.
	always @(negedge clk) begin : driver
		nav_item_t nxt;
		bit        hold_off;
		bit        stall;
		if (arst_n) begin
			case (pace_t'((accepted_cnt / 60) % 4))
				PACE_SEND_IDLE: begin
					hold_off = coin(83);
					stall    = 1'b0;
				end
				PACE_RECV_STALL: begin
					hold_off = 1'b0;
					stall    = coin(83);
				end
				PACE_BOTH: begin
					hold_off = coin(29);
					stall    = coin(29);
				end
				default: begin
					hold_off = 1'b0;
					stall    = 1'b0;
				end
			endcase
			if (!q_valid || q_taken) begin
				if (pend_q.size() != 0 && !hold_off) begin
					nxt = pend_q.pop_front();
					q_item  <= nxt;
					q_valid <= 1'b1;
				end else begin
					q_valid <= 1'b0;
				end
			end
			ans_ready <= !stall;
		end
	end

	// Watchdog: a run that goes too long without any transfer is hung.
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int len;
		int base;
		int r;

		// Directed part. The first query hits a never-loaded entry, which is a
		// boundary, so it answers not found.
		push_item(REQ_NEXT, 0, 0, 1'b0, 1'b0);
		// A small tree at the start of the table: 0 (depth 0) > 1 (1) > 2 (2),
		// 3 (1), then a boundary at 4.
		push_item(REQ_LOAD, 0, 0, 1'b1, 1'b0);
		push_item(REQ_LOAD, 1, 1, 1'b1, 1'b0);
		push_item(REQ_LOAD, 2, 2, 1'b0, 1'b0);
		push_item(REQ_LOAD, 3, 1, 1'b0, 1'b0);
		push_item(REQ_LOAD, 4, 15, 1'b1, 1'b1);
		push_item(REQ_PARENT, 0, 15, 1'b1, 1'b1);  // depth zero has no parent
		push_item(REQ_PREV, 0, 0, 1'b0, 1'b0);     // walks off the table start
		push_item(REQ_PARENT, 2, 0, 1'b0, 1'b0);
		push_item(REQ_CHILD, 0, 0, 1'b0, 1'b0);
		push_item(REQ_NEXT, 1, 0, 1'b0, 1'b0);
		push_item(REQ_PREV, 3, 0, 1'b0, 1'b0);
		push_item(REQ_NEXT, 3, 0, 1'b0, 1'b0);     // stops on the boundary
		push_item(REQ_CHILD, 4, 0, 1'b0, 1'b0);    // query on a boundary entry
		// Deepest entries at the table end.
		push_item(REQ_LOAD, 254, 15, 1'b1, 1'b0);
		push_item(REQ_LOAD, 255, 15, 1'b1, 1'b0);
		push_item(REQ_CHILD, 254, 0, 1'b0, 1'b0);  // deepest level has no child
		push_item(REQ_NEXT, 255, 0, 1'b0, 1'b0);   // walks off the table end
		push_item(REQ_NEXT, 254, 0, 1'b0, 1'b0);
		push_item(REQ_PREV, 255, 0, 1'b0, 1'b0);
		push_item(REQ_PARENT, 255, 0, 1'b0, 1'b0); // never-loaded 253 stops it
		push_item(REQ_LOAD, 253, 14, 1'b1, 1'b0);
		push_item(REQ_PARENT, 255, 0, 1'b0, 1'b0);
		// Undefined request codes are dropped without an answer.
		for (int k = 0; k < 3; k++)
			push_item(REQ_W'(REQ_UNDEF_FIRST + k), 0, 15, 1'b1, 1'b1);
		push_item(REQ_LOAD, 3, 1, 1'b0, 1'b1);     // fence off the sibling of 1
		push_item(REQ_NEXT, 1, 0, 1'b0, 1'b0);

		// Random part: mostly well-formed subtrees with queries around them,
		// with scattered queries and raw loads and dropped codes as noise.
		while (item_cnt < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len  = coin(85) ? $urandom_range(2, 20) : $urandom_range(60, 160);
				base = $urandom_range(0, TABLE_ENTRIES - len);
				add_tree(base, len);
			end else if (r < 88) begin
				for (int k = 0; k < 5; k++)
					push_query($urandom_range(0, TABLE_ENTRIES - 1));
			end else if (r < 96) begin
				push_item(REQ_LOAD, $urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(0, 15),
					$urandom_range(0, 1), $urandom_range(0, 1));
			end else begin
				push_item(REQ_W'(REQ_UNDEF_FIRST + $urandom_range(0, 2)),
					$urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(0, 15),
					$urandom_range(0, 1), $urandom_range(0, 1));
			end
		end

		// Hold reset, then release it away from the rising edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer in, then for every answer owed, then give
		// the block one full walk longer to show any answer it should not send.
		do @(negedge clk); while (pend_q.size() != 0 || q_valid);
		do @(negedge clk); while (answer_due_q.size() != 0);
		repeat (TABLE_ENTRIES + 8) @(negedge clk);

		$display("Run covered %0d item transfers: %0d table loads and %0d answered queries,",
			accepted_cnt, load_cnt, checked_cnt);
		$display("%0d of which found a relative, under four channel pacing phases.", hit_cnt);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[filelist.f]
+incdir+design
design/dtn_pkg.sv
design/dtn_channels.sv
design/dtn_datapath.sv
design/dtn_controller.sv
design/depth_tree_navigator_top.sv
bench/tb_top.sv
